[hdl/pcpa_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the per-CPU page free-list allocator.
// No dependencies; imported by every module of the block.

package pcpa_pkg;

    localparam int CPU_COUNT  = 8;
    localparam int PAGE_COUNT = 32768;
    localparam int PAGE_SHIFT = 12;

    localparam int CPU_W  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int PAGE_W = $clog2(PAGE_COUNT);
    localparam int PFN_W  = 32 - PAGE_SHIFT;

    // Stream payload layout
    localparam int S_DATA_W   = 40;
    localparam int S_CPU_LSB  = 0;
    localparam int S_ADDR_LSB = 3;
    localparam int M_DATA_W   = 40;
    localparam int M_SRC_LSB  = 32;
    localparam int M_STL_BIT  = 35;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam logic REG_POOL_START = 1'b0;
    localparam logic REG_POOL_END   = 1'b1;
    localparam logic [31:0] POOL_START_RST = 32'h8000_0000;
    localparam logic [31:0] POOL_END_RST   = 32'h8800_0000;

    // Opcodes and status codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    typedef struct packed {
        logic capture;
        logic do_free;
        logic rd_issue;
        logic do_pop;
        logic do_empty;
    } ctrl_cmd_t;

    typedef struct packed {
        logic op_free;
        logic any_valid;
        logic out_free;
    } dp_status_t;

endpackage

[hdl/pcpa_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer for the page allocator: capture, execute, pop.
// Depends on pcpa_pkg for the command and status structs.

module pcpa_ctrl import pcpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  dp_status_t dp_st,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [1:0] {IDLE, EXEC, POP} state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = EXEC;
                end
            end
            EXEC:
            begin
                if (dp_st.out_free)
                begin
                    if (dp_st.op_free)
                    begin
                        cmd.do_free = 1'b1;
                        state_next  = IDLE;
                    end
                    else if (dp_st.any_valid)
                    begin
                        cmd.rd_issue = 1'b1;
                        state_next   = POP;
                    end
                    else
                    begin
                        cmd.do_empty = 1'b1;
                        state_next   = IDLE;
                    end
                end
            end
            POP:
            begin
                if (dp_st.out_free)
                begin
                    cmd.do_pop = 1'b1;
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    assign s_axis_tready = (state_reg == IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/pcpa_dp.sv]
`timescale 1ns / 1ps
// Datapath: list heads, next-page memory, address checks and result register.
// Depends on pcpa_pkg; driven by pcpa_ctrl commands.

module pcpa_dp import pcpa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           cmd,
    output dp_status_t          dp_st,
    input  logic                s_axis_tuser,
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    input  logic [31:0]         pool_start,
    input  logic [31:0]         pool_end,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [1:0]          m_axis_tuser,
    output logic [M_DATA_W-1:0] m_axis_tdata
);

    logic              op_reg;
    logic [CPU_W-1:0]  cpu_reg;
    logic [31:0]       addr_reg;

    logic [PAGE_W-1:0] head_reg [CPU_COUNT];
    logic [CPU_COUNT-1:0] valid_reg;
    logic [CPU_COUNT-1:0] valid_next;

    logic [PAGE_W:0]   mem [PAGE_COUNT];
    logic [PAGE_W:0]   rdata_reg;

    logic [CPU_W-1:0]  src_reg;
    logic              stolen_reg;
    logic [PAGE_W-1:0] pg_reg;

    logic                out_valid_reg;
    logic [1:0]          out_user_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    logic [CPU_W-1:0]  low_idx;
    logic [CPU_W-1:0]  src_sel;
    logic              stolen;
    logic [CPU_W-1:0]  head_idx;
    logic [PAGE_W-1:0] head_rd;
    logic [PFN_W-1:0]  pg_full;
    logic [PAGE_W-1:0] pg_new;
    logic              bad;
    logic [PFN_W-1:0]  pfn_out;
    logic [31:0]       alloc_addr;
    logic [M_DATA_W-1:0] pop_data;

    // Own list first, else the lowest-numbered non-empty list
    always_comb
    begin
        low_idx = '0;
        for (int i = CPU_COUNT - 1; i >= 0; i--)
        begin
            if (valid_reg[i])
            begin
                low_idx = CPU_W'(i);
            end
        end
    end

    assign stolen   = !valid_reg[cpu_reg];
    assign src_sel  = stolen ? low_idx : cpu_reg;
    assign head_idx = (op_reg == OP_FREE) ? cpu_reg : src_sel;
    assign head_rd  = head_reg[head_idx];

    assign pg_full = addr_reg[31:PAGE_SHIFT] - pool_start[31:PAGE_SHIFT];
    assign pg_new  = pg_full[PAGE_W-1:0];
    assign bad     = (addr_reg[PAGE_SHIFT-1:0] != '0)
                  || (addr_reg < pool_start)
                  || (addr_reg >= pool_end)
                  || ({1'b0, pg_full} >= (PFN_W + 1)'(PAGE_COUNT));

    assign pfn_out    = PFN_W'(pg_reg) + pool_start[31:PAGE_SHIFT];
    assign alloc_addr = {pfn_out, {PAGE_SHIFT{1'b0}}};

    // Payload of a successful allocate
    always_comb
    begin
        pop_data                     = '0;
        pop_data[31:0]               = alloc_addr;
        pop_data[M_SRC_LSB +: 3]     = 3'(src_reg);
        pop_data[M_STL_BIT]          = stolen_reg;
    end

    assign dp_st.op_free   = (op_reg == OP_FREE);
    assign dp_st.any_valid = |valid_reg;
    assign dp_st.out_free  = !out_valid_reg || m_axis_tready;

    // Input capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= s_axis_tuser;
            cpu_reg  <= s_axis_tdata[S_CPU_LSB +: CPU_W];
            addr_reg <= s_axis_tdata[S_ADDR_LSB +: 32];
        end
    end

    // Next-page memory and list heads
    always_ff @(posedge clk)
    begin
        if (cmd.do_free && !bad)
        begin
            mem[pg_new]       <= valid_reg[cpu_reg] ? {1'b1, head_rd} : '0;
            head_reg[cpu_reg] <= pg_new;
        end
        if (cmd.rd_issue)
        begin
            rdata_reg  <= mem[head_rd];
            pg_reg     <= head_rd;
            src_reg    <= src_sel;
            stolen_reg <= stolen;
        end
        if (cmd.do_pop)
        begin
            head_reg[src_reg] <= rdata_reg[PAGE_W] ? rdata_reg[PAGE_W-1:0] : '0;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.do_free && !bad)
        begin
            valid_next[cpu_reg] = 1'b1;
        end
        if (cmd.do_pop)
        begin
            valid_next[src_reg] = rdata_reg[PAGE_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.do_free || cmd.do_empty || cmd.do_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_free)
        begin
            out_user_reg <= bad ? ST_BAD : ST_OK;
            out_data_reg <= '0;
        end
        else if (cmd.do_empty)
        begin
            out_user_reg <= ST_EMPTY;
            out_data_reg <= '0;
        end
        else if (cmd.do_pop)
        begin
            out_user_reg <= ST_OK;
            out_data_reg <= pop_data;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

[hdl/per_cpu_page_free_list_allocator.sv]
`timescale 1ns / 1ps
// Top level of the per-CPU page free-list allocator: APB registers,
// sequencer and datapath. Depends on pcpa_pkg, pcpa_ctrl and pcpa_dp.
//
// Usage:
//   Requests arrive on the s_axis channel, one transaction per request:
//   tuser carries the opcode (0 allocate, 1 free), tdata the CPU index and
//   the address of the page to free. Every request yields exactly one
//   result transaction on m_axis: tuser is the status (0 ok, 1 nothing
//   free, 2 bad free address), tdata the allocated page address, the CPU
//   whose list supplied it and a stolen flag.
//   Sequence: a free, or an allocate with every list empty, goes from capture
//   to the execute state, which loads the result register; an allocate that
//   pops a page also passes the pop state for the registered next-page read.
//   One request runs at a time; none is taken until the last leaves EXEC/POP.
//   Stalls: the result sits in an output register; the next request may
//   be accepted while it waits, but its execution holds until the
//   receiver takes the pending result.
//   Reset: every list is empty and pool_start / pool_end take their reset
//   values. The next-page memory is not cleared; software fills the pool
//   by issuing frees. Write the pool registers only while idle.

module per_cpu_page_free_list_allocator import pcpa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // Request stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic                  s_axis_tuser,  // [0] opcode
    input  logic [S_DATA_W-1:0]   s_axis_tdata,  // [2:0] cpu_index, [34:3] free_addr
    // Result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [1:0]            m_axis_tuser,  // [1:0] status
    output logic [M_DATA_W-1:0]   m_axis_tdata   // [31:0] page_addr, [34:32] source_cpu,
                                                 // [35] stolen
);

    logic [31:0] pool_start_reg;
    logic [31:0] pool_end_reg;
    logic        cfg_wr;

    ctrl_cmd_t  cmd;
    dp_status_t dp_st;

    // Registers sit at byte addresses 0 and 4; decode on paddr bit 2
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_start_reg <= POOL_START_RST;
            pool_end_reg   <= POOL_END_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_POOL_START: pool_start_reg <= pwdata;
                REG_POOL_END:   pool_end_reg   <= pwdata;
                default:        pool_start_reg <= pool_start_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_POOL_START: prdata = pool_start_reg;
            REG_POOL_END:   prdata = pool_end_reg;
            default:        prdata = '0;
        endcase
    end

    // Sequencer: capture, execute, and pop once the memory read returns
    pcpa_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .dp_st         (dp_st),
        .cmd           (cmd)
    );

    // Datapath: list heads, next-page memory, checks and result register
    pcpa_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .dp_st         (dp_st),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .pool_start    (pool_start_reg),
        .pool_end      (pool_end_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

[hdl/pcpa_chk.sv]
`timescale 1ns / 1ps
// Port-level checker for the page allocator, bound to the top level.
// Depends on pcpa_pkg for widths and status codes.

module pcpa_chk import pcpa_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [1:0]            m_axis_tuser,
    input logic [M_DATA_W-1:0]   m_axis_tdata
);

    // A pending result stays until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // One request at a time: no back-to-back acceptance
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while previous one executes");

    // Only defined status codes appear
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_EMPTY
                           || m_axis_tuser == ST_BAD))
        else $error("undefined status code");

    // Failed requests carry an all-zero payload
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == '0)
        else $error("non-zero payload on failed request");

endmodule

bind per_cpu_page_free_list_allocator pcpa_chk u_pcpa_chk
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
);
